/* rtl/latin_hypercube_index_draw_macros.svh */
// Assertion helpers shared by the index draw RTL.
`ifndef LATIN_HYPERCUBE_INDEX_DRAW_MACROS_SVH
`define LATIN_HYPERCUBE_INDEX_DRAW_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define LHID_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define LHID_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lhid_pkg.sv */
package lhid_pkg;

   // Default sizes of the bin lists
   localparam int MAX_SAMPLES_DEF = 256;
   localparam int MAX_VARS_DEF    = 8;

   // Fixed field widths
   localparam int WORD_W = 31;
   localparam int NS_W   = 9;
   localparam int NV_W   = 4;
   localparam int ROW_W  = 8;
   localparam int COL_W  = 3;
   localparam int BIN_W  = 8;

   // Register port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   // Register indexes, decoded from paddr[2]
   localparam logic REG_NUM_SAMPLES = 1'b0;
   localparam logic REG_NUM_VARS    = 1'b1;

   // Register reset values
   localparam logic [NS_W-1:0] NUM_SAMPLES_RST = NS_W'(256);
   localparam logic [NV_W-1:0] NUM_VARS_RST    = NV_W'(1);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_FETCH,
      ST_BIN,
      ST_SHIFT,
      ST_OUT
   } state_type;

endpackage

/* rtl/latin_hypercube_index_draw.sv */
// Latin hypercube index matrix generator.
// Input channel req_: one 31-bit random word per matrix cell; cells fill in row-major
// order. Result channel rsp_: one word per input with the cell's row, column, the drawn
// bin and row/matrix end flags. Each column keeps its own list of unused bins in a
// single-port-write, registered-read memory.
// Each word passes through the bit-serial remainder unit, then the picked bin is
// fetched, then the list entries after it (remaining - 1 - pick position of them) are
// moved down one place each, then the result is presented. The entry-by-entry shift
// through the memory port dominates the time per word.
// After reset, after every register write and after the last cell of a matrix, the lists
// are refilled by a pass that writes num_samples * num_vars entries, one entry per cycle,
// with req_ready low. The reset pass refills 256 entries at the default register values.
// While a result waits for rsp_ready the block holds it and takes no new word.
// Registers: num_samples at byte address 0, num_vars at byte address 4; a write to
// either restarts the matrix. Write only while the block is idle.
`include "latin_hypercube_index_draw_macros.svh"

module latin_hypercube_index_draw #(
   parameter int MAX_SAMPLES = lhid_pkg::MAX_SAMPLES_DEF,
   parameter int MAX_VARS    = lhid_pkg::MAX_VARS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input words
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lhid_pkg::WORD_W-1:0]      req_random_word,
   // result words
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lhid_pkg::ROW_W-1:0]       rsp_sample_row,
   output logic [lhid_pkg::COL_W-1:0]       rsp_var_column,
   output logic [lhid_pkg::BIN_W-1:0]       rsp_chosen_bin,
   output logic                             rsp_row_last,
   output logic                             rsp_matrix_last,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lhid_pkg::PADDR_W-1:0]     paddr,
   input  logic [lhid_pkg::PDATA_W-1:0]     pwdata,
   output logic [lhid_pkg::PDATA_W-1:0]     prdata,
   output logic                             pready
);

   localparam int IW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int MW = $clog2(MAX_VARS + 1);
   localparam int AW = VW + IW;

   lhid_pkg::state_type state_ff, state_in;

   logic [lhid_pkg::NS_W-1:0] num_samples_ff, num_samples_in;
   logic [lhid_pkg::NV_W-1:0] num_vars_ff, num_vars_in;
   logic [CW-1:0]             rem_ff, rem_in;
   logic [IW-1:0]             row_ff, row_in;
   logic [VW-1:0]             col_ff, col_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [IW-1:0]             clr_idx_ff, clr_idx_in;
   logic [VW-1:0]             clr_col_ff, clr_col_in;
   logic [IW-1:0]             bin_ff, bin_in;
   logic                      rlast_ff, rlast_in;
   logic                      mlast_ff, mlast_in;

   logic [CW-1:0]             n_eff;
   logic [MW-1:0]             m_eff;
   logic [CW-1:0]             rem_div;
   logic [31:0]               ns32, nv32;
   logic                      cfg_wr;
   logic                      req_acc, rsp_acc;
   logic                      rlast_now, mlast_now;
   logic                      finish;

   logic                      mod_done;
   logic [IW-1:0]             mod_result;

   logic                      wr_en, rd_en;
   logic [AW-1:0]             wr_addr, rd_addr;
   logic [IW-1:0]             wr_data, rd_data;

   logic [31:0]               row32, col32, bin32;

   // Effective register values
   always_comb begin
      ns32 = 32'(num_samples_ff);
      nv32 = 32'(num_vars_ff);
      if (ns32 == 32'd0) begin
         n_eff = CW'(1);
      end else if (ns32 > 32'(MAX_SAMPLES)) begin
         n_eff = CW'(MAX_SAMPLES);
      end else begin
         n_eff = CW'(ns32);
      end
      if (nv32 == 32'd0) begin
         m_eff = MW'(1);
      end else if (nv32 > 32'(MAX_VARS)) begin
         m_eff = MW'(MAX_VARS);
      end else begin
         m_eff = MW'(nv32);
      end
      rem_div = (rem_ff == '0) ? CW'(1) : rem_ff;
   end

   assign cfg_wr    = psel && penable && pwrite && pready;
   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign rlast_now = (32'(col_ff) + 32'd1) >= 32'(m_eff);
   assign mlast_now = rlast_now && ((32'(row_ff) + 32'd1) >= 32'(n_eff));

   // Register read
   always_comb begin
      unique case (paddr[2])
         lhid_pkg::REG_NUM_SAMPLES: prdata = lhid_pkg::PDATA_W'(num_samples_ff);
         lhid_pkg::REG_NUM_VARS:    prdata = lhid_pkg::PDATA_W'(num_vars_ff);
         default:                   prdata = '0;
      endcase
   end
   assign pready = 1'b1;

   // Sequencer: next state and memory port control
   always_comb begin
      state_in       = state_ff;
      num_samples_in = num_samples_ff;
      num_vars_in    = num_vars_ff;
      rem_in         = rem_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      idx_in         = idx_ff;
      clr_idx_in     = clr_idx_ff;
      clr_col_in     = clr_col_ff;
      bin_in         = bin_ff;
      rlast_in       = rlast_ff;
      mlast_in       = mlast_ff;
      finish         = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = {clr_col_ff, clr_idx_ff};
      wr_data        = clr_idx_ff;
      rd_en          = 1'b0;
      rd_addr        = {col_ff, idx_ff};

      unique case (state_ff)
         lhid_pkg::ST_CLEAR: begin
            // refill entry with its own index
            wr_en  = 1'b1;
            rem_in = n_eff;
            if ((32'(clr_idx_ff) + 32'd1) >= 32'(n_eff)) begin
               clr_idx_in = '0;
               if ((32'(clr_col_ff) + 32'd1) >= 32'(m_eff)) begin
                  clr_col_in = '0;
                  state_in   = lhid_pkg::ST_IDLE;
               end else begin
                  clr_col_in = clr_col_ff + VW'(1);
               end
            end else begin
               clr_idx_in = clr_idx_ff + IW'(1);
            end
         end
         lhid_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = lhid_pkg::ST_MOD;
            end
         end
         lhid_pkg::ST_MOD: begin
            if (mod_done) begin
               idx_in   = mod_result;
               state_in = lhid_pkg::ST_FETCH;
            end
         end
         lhid_pkg::ST_FETCH: begin
            // read the picked entry
            rd_en    = 1'b1;
            state_in = lhid_pkg::ST_BIN;
         end
         lhid_pkg::ST_BIN: begin
            bin_in = rd_data;
            if ((32'(idx_ff) + 32'd1) < 32'(rem_div)) begin
               rd_en    = 1'b1;
               rd_addr  = {col_ff, IW'(32'(idx_ff) + 32'd1)};
               state_in = lhid_pkg::ST_SHIFT;
            end else begin
               finish = 1'b1;
            end
         end
         lhid_pkg::ST_SHIFT: begin
            // move the following entry down one place
            wr_en   = 1'b1;
            wr_addr = {col_ff, idx_ff};
            wr_data = rd_data;
            if ((32'(idx_ff) + 32'd2) < 32'(rem_div)) begin
               rd_en   = 1'b1;
               rd_addr = {col_ff, IW'(32'(idx_ff) + 32'd2)};
               idx_in  = idx_ff + IW'(1);
            end else begin
               finish = 1'b1;
            end
         end
         lhid_pkg::ST_OUT: begin
            if (rsp_acc) begin
               state_in = lhid_pkg::ST_IDLE;
               if (mlast_ff) begin
                  row_in     = '0;
                  col_in     = '0;
                  clr_idx_in = '0;
                  clr_col_in = '0;
                  state_in   = lhid_pkg::ST_CLEAR;
               end else if (rlast_ff) begin
                  col_in = '0;
                  row_in = row_ff + IW'(1);
                  rem_in = rem_div - CW'(1);
               end else begin
                  col_in = col_ff + VW'(1);
                  rem_in = rem_div;
               end
            end
         end
         default: state_in = lhid_pkg::ST_CLEAR;
      endcase

      // latch end flags with the result
      if (finish) begin
         rlast_in = rlast_now;
         mlast_in = mlast_now;
         state_in = lhid_pkg::ST_OUT;
      end

      // any register write restarts the matrix
      if (cfg_wr) begin
         if (paddr[2] == lhid_pkg::REG_NUM_VARS) begin
            num_vars_in = pwdata[lhid_pkg::NV_W-1:0];
         end else begin
            num_samples_in = pwdata[lhid_pkg::NS_W-1:0];
         end
         row_in     = '0;
         col_in     = '0;
         clr_idx_in = '0;
         clr_col_in = '0;
         state_in   = lhid_pkg::ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lhid_pkg::ST_CLEAR;
         num_samples_ff <= lhid_pkg::NUM_SAMPLES_RST;
         num_vars_ff    <= lhid_pkg::NUM_VARS_RST;
         row_ff         <= '0;
         col_ff         <= '0;
         clr_idx_ff     <= '0;
         clr_col_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         num_samples_ff <= num_samples_in;
         num_vars_ff    <= num_vars_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         clr_idx_ff     <= clr_idx_in;
         clr_col_ff     <= clr_col_in;
      end
      rem_ff   <= rem_in;
      idx_ff   <= idx_in;
      bin_ff   <= bin_in;
      rlast_ff <= rlast_in;
      mlast_ff <= mlast_in;
   end

   lhid_mod_unit #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (req_acc),
      .word    (req_random_word),
      .divisor (rem_div),
      .done    (mod_done),
      .result  (mod_result)
   );

   lhid_bin_store #(
      .AW (AW),
      .DW (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Drive result word from held state
   assign row32           = 32'(row_ff);
   assign col32           = 32'(col_ff);
   assign bin32           = 32'(bin_ff);
   assign req_ready       = (state_ff == lhid_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == lhid_pkg::ST_OUT);
   assign rsp_sample_row  = row32[lhid_pkg::ROW_W-1:0];
   assign rsp_var_column  = col32[lhid_pkg::COL_W-1:0];
   assign rsp_chosen_bin  = bin32[lhid_pkg::BIN_W-1:0];
   assign rsp_row_last    = rlast_ff;
   assign rsp_matrix_last = mlast_ff;

   `LHID_ASSERT_IMP(a_mlast_has_rlast, rsp_valid && rsp_matrix_last, rsp_row_last, "matrix end without row end")
   `LHID_ASSERT_NXT(a_busy_after_req, req_acc && !cfg_wr, !req_ready, "ready right after taking a word")
   `LHID_ASSERT_NXT(a_refill_after_matrix, rsp_acc && rsp_matrix_last, state_ff == lhid_pkg::ST_CLEAR, "no refill after matrix end")
   `LHID_ASSERT_IMP(a_col_in_range, rsp_valid, (32'(col_ff) + 32'd1) <= 32'(m_eff), "column beyond num_vars")

endmodule

/* rtl/lhid_mod_unit.sv */
`include "latin_hypercube_index_draw_macros.svh"

module lhid_mod_unit #(
   parameter int MAX_SAMPLES = lhid_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [lhid_pkg::WORD_W-1:0]           word,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]      divisor,
   output logic                                  done,
   output logic [$clog2(MAX_SAMPLES)-1:0]        result
);

   localparam int CW    = $clog2(MAX_SAMPLES + 1);
   localparam int IW    = $clog2(MAX_SAMPLES);
   localparam int WW    = lhid_pkg::WORD_W;
   localparam int CNT_W = $clog2(WW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WW-1:0]    word_ff, word_in;
   logic [CW-1:0]    div_ff, div_in;
   logic [CW-1:0]    acc_ff, acc_in;
   logic [CW:0]      trial;

   // One restoring remainder step per cycle, most significant bit first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      word_in = word_ff;
      div_in  = div_ff;
      acc_in  = acc_ff;
      trial   = {acc_ff, word_ff[WW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WW - 1);
         word_in = word;
         div_in  = divisor;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            acc_in = CW'(trial - {1'b0, div_ff});
         end else begin
            acc_in = trial[CW-1:0];
         end
         word_in = {word_ff[WW-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      word_ff <= word_in;
      div_ff  <= div_in;
      acc_ff  <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff[IW-1:0];

   `LHID_ASSERT_IMP(a_rem_below_div, done_ff, acc_ff < div_ff, "remainder not below divisor")
   `LHID_ASSERT_IMP(a_done_not_busy, done_ff, !busy_ff, "done while still iterating")
   `LHID_ASSERT_NXT(a_start_sets_busy, start, busy_ff, "start did not begin iterating")

endmodule

/* rtl/lhid_bin_store.sv */
module lhid_bin_store #(
   parameter int AW = 11,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* test/latin_hypercube_index_draw_test.sv */
module latin_hypercube_index_draw_test;

   localparam int N_MAX       = lhid_pkg::MAX_SAMPLES_DEF;
   localparam int V_MAX       = lhid_pkg::MAX_VARS_DEF;
   localparam int IDLE_LIMIT  = 20000;
   localparam int TAIL_CYCLES = 400;
   localparam int WORDS_PER_SETTING = 70;

   localparam int WORD_W  = lhid_pkg::WORD_W;
   localparam int NS_W    = lhid_pkg::NS_W;
   localparam int NV_W    = lhid_pkg::NV_W;
   localparam int ROW_W   = lhid_pkg::ROW_W;
   localparam int COL_W   = lhid_pkg::COL_W;
   localparam int BIN_W   = lhid_pkg::BIN_W;
   localparam int PADDR_W = lhid_pkg::PADDR_W;
   localparam int PDATA_W = lhid_pkg::PDATA_W;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [BIN_W-1:0] bin;
      logic             row_last;
      logic             matrix_last;
   } cell_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [WORD_W-1:0]  req_random_word = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [ROW_W-1:0]   rsp_sample_row;
   logic [COL_W-1:0]   rsp_var_column;
   logic [BIN_W-1:0]   rsp_chosen_bin;
   logic               rsp_row_last;
   logic               rsp_matrix_last;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   // predicted block state: one free-bin list per column
   logic [BIN_W-1:0] bin_lists [V_MAX][N_MAX];
   logic [NS_W-1:0]  cfg_samples;
   logic [NV_W-1:0]  cfg_vars;
   int unsigned      free_cnt;
   int unsigned      cur_row;
   int unsigned      cur_col;
   cell_type         expected_cells [$];

   int errors = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   latin_hypercube_index_draw u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_row  (rsp_sample_row),
      .rsp_var_column  (rsp_var_column),
      .rsp_chosen_bin  (rsp_chosen_bin),
      .rsp_row_last    (rsp_row_last),
      .rsp_matrix_last (rsp_matrix_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // clamp the register values to the sizes the block supports
   function automatic int unsigned samples_in_use();
      if (cfg_samples == 0) return 1;
      if (cfg_samples > N_MAX) return N_MAX;
      return cfg_samples;
   endfunction

   function automatic int unsigned vars_in_use();
      if (cfg_vars == 0) return 1;
      if (cfg_vars > V_MAX) return V_MAX;
      return cfg_vars;
   endfunction

   // refill every list with 0 to N-1 and start a new matrix
   function automatic void restart_lists();
      int v;
      int i;
      for (v = 0; v < V_MAX; v++)
         for (i = 0; i < N_MAX; i++)
            bin_lists[v][i] = BIN_W'(i);
      free_cnt = samples_in_use();
      cur_row = 0;
      cur_col = 0;
   endfunction

   // draw one bin for the next cell and drop it from its column list
   function automatic cell_type draw_cell(input logic [WORD_W-1:0] w);
      int unsigned n;
      int unsigned m;
      int unsigned rem;
      int unsigned col;
      int unsigned pos;
      int unsigned idx;
      cell_type c;
      n = samples_in_use();
      m = vars_in_use();
      rem = free_cnt;
      if (rem == 0) rem = 1;
      if (rem > N_MAX) rem = N_MAX;
      col = (cur_col < V_MAX) ? cur_col : 0;
      pos = 32'(w) % rem;
      c.row = ROW_W'(cur_row);
      c.col = COL_W'(col);
      c.bin = bin_lists[col][pos];
      for (idx = pos; idx + 1 < rem; idx++)
         bin_lists[col][idx] = bin_lists[col][idx + 1];
      c.row_last = (col + 1 >= m);
      c.matrix_last = c.row_last && (cur_row + 1 >= n);
      if (c.matrix_last) begin
         restart_lists();
      end else if (c.row_last) begin
         cur_col = 0;
         cur_row = cur_row + 1;
         free_cnt = rem - 1;
      end else begin
         cur_col = col + 1;
         free_cnt = rem;
      end
      return c;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // drive the stall pattern, check result words, track the prediction
   always @(posedge clock) begin
      cell_type want;
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               $display("%0t: unexpected result word, expected none actual row %0d col %0d bin %0d",
                        $time, rsp_sample_row, rsp_var_column, rsp_chosen_bin);
               errors++;
            end else begin
               want = expected_cells.pop_front();
               check_field("sample_row", 8'(want.row), 8'(rsp_sample_row));
               check_field("var_column", 8'(want.col), 8'(rsp_var_column));
               check_field("chosen_bin", 8'(want.bin), 8'(rsp_chosen_bin));
               check_field("row_last", 8'(want.row_last), 8'(rsp_row_last));
               check_field("matrix_last", 8'(want.matrix_last), 8'(rsp_matrix_last));
            end
         end
         if (req_valid && req_ready)
            expected_cells.insert(expected_cells.size(), draw_cell(req_random_word));
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == lhid_pkg::REG_NUM_VARS)
               cfg_vars = pwdata[NV_W-1:0];
            else
               cfg_samples = pwdata[NS_W-1:0];
            restart_lists();
         end
         // watchdog: count cycles in which no word moves
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (psel && penable && pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("[latin_hypercube_index_draw] ERROR");
            $finish;
         end
      end
   end

   function automatic logic [WORD_W-1:0] random_word_value();
      case ($urandom_range(0, 3))
         0: return WORD_W'($urandom_range(0, 511));
         1: return {WORD_W{1'b1}} - WORD_W'($urandom_range(0, 255));
         default: return WORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [NS_W-1:0] pick_samples();
      case ($urandom_range(0, 7))
         0: return NS_W'($urandom_range(13, N_MAX));
         1: return NS_W'($urandom_range(0, 511));
         default: return NS_W'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [NV_W-1:0] pick_vars();
      if ($urandom_range(0, 5) == 0) return NV_W'($urandom_range(0, 15));
      return NV_W'($urandom_range(1, V_MAX));
   endfunction

   // present one word, idling first at the current rate; hold it until taken
   task automatic send_word(input logic [WORD_W-1:0] w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_random_word <= random_word_value();
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_random_word <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid, wait for all results, then for the block to leave its refill pass
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_cells.size() != 0);
      repeat (4) @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // one register access; a read compares prdata with the given value
   task automatic bus_access(input logic write, input logic idx, input logic [PDATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= PADDR_W'({idx, 2'b00});
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (!write && prdata !== data) begin
         $display("%0t: register %0d readback mismatch, expected %0d actual %0d",
                  $time, idx, data, prdata);
         errors++;
      end
   endtask

   // write both registers (noise in the unused data bits) and read them back
   task automatic configure(input logic [NS_W-1:0] ns, input logic [NV_W-1:0] nv);
      logic [PDATA_W-1:0] wdata;
      wait_idle();
      wdata = $urandom;
      wdata[NS_W-1:0] = ns;
      bus_access(1'b1, lhid_pkg::REG_NUM_SAMPLES, wdata);
      bus_access(1'b0, lhid_pkg::REG_NUM_SAMPLES, PDATA_W'(ns));
      wdata = $urandom;
      wdata[NV_W-1:0] = nv;
      bus_access(1'b1, lhid_pkg::REG_NUM_VARS, wdata);
      bus_access(1'b0, lhid_pkg::REG_NUM_VARS, PDATA_W'(nv));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // reset values: one column of 256 bins, extreme and patterned words
   task automatic test_default_config();
      send_word('0);
      send_word({WORD_W{1'b1}});
      send_word(WORD_W'(255));
      send_word(WORD_W'(256));
      send_word(WORD_W'(32'h5555_5555));
      send_word(WORD_W'(32'h2AAA_AAAA));
   endtask

   // register extremes and out-of-range values, each restarting the matrix
   task automatic test_register_limits();
      configure(NS_W'(1), NV_W'(V_MAX));
      repeat (V_MAX + 1) send_word(random_word_value());
      configure('0, '0);
      repeat (2) send_word(random_word_value());
      configure({NS_W{1'b1}}, {NV_W{1'b1}});
      repeat (3) send_word(random_word_value());
   endtask

   // one full small matrix and the first cell of the next
   task automatic test_small_matrix();
      configure(NS_W'(2), NV_W'(3));
      repeat (7) send_word(random_word_value());
   endtask

   // random words over several settings, the first one given
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [NS_W-1:0] first_ns,
                                      input logic [NV_W-1:0] first_nv);
      int s;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (s = 0; s < 5; s++) begin
         if (s == 0)
            configure(first_ns, first_nv);
         else
            configure(pick_samples(), pick_vars());
         repeat (WORDS_PER_SETTING) send_word(random_word_value());
      end
   endtask

   initial begin
      cfg_samples = lhid_pkg::NUM_SAMPLES_RST;
      cfg_vars = lhid_pkg::NUM_VARS_RST;
      restart_lists();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_default_config();
      test_register_limits();
      test_small_matrix();
      test_random_traffic(0, 0, NS_W'(N_MAX), NV_W'(V_MAX));
      test_random_traffic(64, 0, NS_W'(1), NV_W'(1));
      test_random_traffic(0, 64, NS_W'(N_MAX), NV_W'(1));
      test_random_traffic(21, 21, NS_W'(1), NV_W'(V_MAX));

      // drain and give late or spurious words time to show up
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_cells.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("[latin_hypercube_index_draw] OK");
      else
         $display("[latin_hypercube_index_draw] ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/lhid_pkg.sv
rtl/lhid_mod_unit.sv
rtl/lhid_bin_store.sv
rtl/latin_hypercube_index_draw.sv
test/latin_hypercube_index_draw_test.sv
